@@ sv/ceu_pkg.sv @@
`timescale 1ns / 1ps

package ceu_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int MUL_CHUNK    = 16;
    localparam int NUM_UOPS     = 22;
    localparam int PC_BITS      = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN_A    = 3'd0,
        CFG_GAIN_B    = 3'd1,
        CFG_GAIN_C    = 3'd2,
        CFG_SLOPE_D   = 3'd3,
        CFG_SLOPE_E   = 3'd4,
        CFG_TIME_STEP = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_MUL_WAIT,
        ST_COMMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_ABS,
        OP_MUL
    } t_op;

    typedef enum logic [3:0] {
        SRC_X,
        SRC_Y,
        SRC_Z,
        SRC_ONE,
        SRC_A,
        SRC_B,
        SRC_C,
        SRC_D,
        SRC_E,
        SRC_H,
        SRC_T1,
        SRC_T2
    } t_src;

    typedef enum logic [2:0] {
        DST_T1,
        DST_T2,
        DST_NX,
        DST_NY,
        DST_NZ
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src src_a;
        t_src src_b;
        t_dst dst;
    } t_uop;

    typedef struct packed {
        logic start;   // new step: clear overflow flag
        logic issue;   // execute uop this cycle
        t_uop uop;
        logic commit;  // store new point and load output register
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
    } t_dp_sts;

    // One Euler step. Every operand comes from the previous point.
    localparam t_uop PROGRAM [NUM_UOPS] = '{
        '{OP_MUL, SRC_H,  SRC_C,   DST_T1},  // h*c
        '{OP_MUL, SRC_T1, SRC_Y,   DST_T1},  // (h*c)*y
        '{OP_SUB, SRC_Z,  SRC_T1,  DST_NZ},  // z'
        '{OP_MUL, SRC_H,  SRC_B,   DST_T1},  // h*b
        '{OP_SUB, SRC_X,  SRC_Y,   DST_T2},  // x-y
        '{OP_ADD, SRC_T2, SRC_Z,   DST_T2},  // (x-y)+z
        '{OP_MUL, SRC_T1, SRC_T2,  DST_T1},
        '{OP_ADD, SRC_Y,  SRC_T1,  DST_NY},  // y'
        '{OP_ADD, SRC_X,  SRC_ONE, DST_T1},  // x+1
        '{OP_ABS, SRC_T1, SRC_T1,  DST_T1},
        '{OP_SUB, SRC_X,  SRC_ONE, DST_T2},  // x-1
        '{OP_ABS, SRC_T2, SRC_T2,  DST_T2},
        '{OP_SUB, SRC_T1, SRC_T2,  DST_T1},  // diff
        '{OP_ADD, SRC_D,  SRC_E,   DST_T2},  // d+e
        '{OP_MUL, SRC_T2, SRC_T1,  DST_T1},  // (d+e)*diff
        '{OP_MUL, SRC_E,  SRC_X,   DST_T2},  // e*x
        '{OP_ADD, SRC_T2, SRC_T1,  DST_T1},  // g
        '{OP_SUB, SRC_Y,  SRC_X,   DST_T2},  // y-x
        '{OP_SUB, SRC_T2, SRC_T1,  DST_T1},  // (y-x)-g
        '{OP_MUL, SRC_H,  SRC_A,   DST_T2},  // h*a
        '{OP_MUL, SRC_T2, SRC_T1,  DST_T1},
        '{OP_ADD, SRC_X,  SRC_T1,  DST_NX}   // x'
    };

endpackage

@@ sv/ceu_if.sv @@
`timescale 1ns / 1ps

interface ceu_tick_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);
endinterface

interface ceu_cfg_if import ceu_pkg::*; #(
    parameter int WORD_BITS = 32
);
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [WORD_BITS-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface ceu_result_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] next_x;
    logic signed [WORD_BITS-1:0] next_y;
    logic signed [WORD_BITS-1:0] next_z;
    logic                        overflow;

    modport source (output valid, output next_x, output next_y, output next_z,
                    output overflow, input ready);
    modport sink (input valid, input next_x, input next_y, input next_z,
                  input overflow, output ready);
endinterface

@@ sv/chua_attractor_euler_step_unit.sv @@
`timescale 1ns / 1ps

// Channel   Role     Handshake      Payload
// i_tick    request  valid/ready    tick (1 = advance one step)
// i_cfg     config   valid/ready    index, data (gains a b c, slopes d e, step h)
// o_result  result   valid/ready    next_x, next_y, next_z, overflow
//
// Datapath: one shared multiplier (one 16-bit digit per cycle) serves the 8
//   products of a step; the 14 add/sub/abs ops go through the ALU.
// Reset: synchronous, active low; point returns to (1,1,1), config
//   registers to their defaults. No clearing pass.
// Stalls: a held result does not block the next tick; a step only waits at
//   its commit for the output register to empty. Config is always ready.

module chua_attractor_euler_step_unit import ceu_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ceu_tick_if.sink     i_tick,
    ceu_cfg_if.sink      i_cfg,
    ceu_result_if.source o_result
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // registers load straight from the port
    assign i_cfg.ready = 1'b1;

    // sequencer: walks the uop program, one step per accepted tick
    ceu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_tick.valid),
        .i_tick      (i_tick.tick),
        .o_in_ready  (i_tick.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // point state, config registers, saturating ALU and digit multiplier
    ceu_dpath #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_next_x    (o_result.next_x),
        .o_next_y    (o_result.next_y),
        .o_next_z    (o_result.next_z),
        .o_overflow  (o_result.overflow)
    );

endmodule

@@ sv/ceu_dpath.sv @@
`timescale 1ns / 1ps

module ceu_dpath import ceu_pkg::*; #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic                        i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    output logic signed [WORD_BITS-1:0] o_next_x,
    output logic signed [WORD_BITS-1:0] o_next_y,
    output logic signed [WORD_BITS-1:0] o_next_z,
    output logic                        o_overflow
);

    localparam int NCH      = (WORD_BITS + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BP       = NCH * MUL_CHUNK;
    localparam int AW       = WORD_BITS + BP;
    localparam int PW       = AW + 1;
    localparam int CNT_BITS = $clog2(NCH + 1);

    localparam logic [WORD_BITS-1:0] MAX_W = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] MIN_W = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Q8.24 code rescaled to the word format, saturated.
    function automatic logic [WORD_BITS:0] from_q24(input logic signed [63:0] v);
        logic signed [127:0]    t;
        logic [128-WORD_BITS:0] top;
        t = {{64{v[63]}}, v};
        if (FRAC_BITS >= 24) begin
            t = t <<< (FRAC_BITS - 24);
        end else begin
            t = t >>> (24 - FRAC_BITS);
        end
        top = t[127:WORD_BITS-1];
        if ((top == '0) || (top == '1)) begin
            return {1'b0, t[WORD_BITS-1:0]};
        end
        return {1'b1, (t[127] ? MIN_W : MAX_W)};
    endfunction

    // {saturated flag, clamped word}
    function automatic logic [WORD_BITS:0] sat_w(input logic signed [PW-1:0] v);
        logic [PW-WORD_BITS:0] top;
        top = v[PW-1:WORD_BITS-1];
        if ((top == '0) || (top == '1)) begin
            return {1'b0, v[WORD_BITS-1:0]};
        end
        return {1'b1, (v[PW-1] ? MIN_W : MAX_W)};
    endfunction

    localparam logic [WORD_BITS:0] ONE_Q = from_q24(64'sd16777216);
    localparam logic [WORD_BITS-1:0] ONE = ONE_Q[WORD_BITS-1:0];
    localparam logic ONE_SAT = ONE_Q[WORD_BITS];
    localparam logic [WORD_BITS:0] RST_A_Q = from_q24(64'sd243269632);
    localparam logic [WORD_BITS:0] RST_B_Q = from_q24(64'sd16777216);
    localparam logic [WORD_BITS:0] RST_C_Q = from_q24(64'sd429161185);
    localparam logic [WORD_BITS:0] RST_D_Q = from_q24(-64'sd16777216);
    localparam logic [WORD_BITS:0] RST_E_Q = from_q24(64'sd0);
    localparam logic [WORD_BITS:0] RST_H_Q = from_q24(64'sd167772);

    logic [WORD_BITS-1:0] r_gain_a, r_gain_b, r_gain_c, r_slope_d, r_slope_e, r_time_step;
    logic [WORD_BITS-1:0] r_x, r_y, r_z, r_t1, r_t2, r_nx, r_ny, r_nz;
    logic                 r_sat_hit;

    logic                 r_mul_busy;
    logic                 r_mul_fin;
    logic [CNT_BITS-1:0]  r_mul_cnt;
    logic [WORD_BITS-1:0] r_mul_a;
    logic [BP-1:0]        r_mul_b;
    logic                 r_mul_neg;
    logic [AW-1:0]        r_mul_acc;
    t_dst                 r_mul_dst;

    logic [WORD_BITS-1:0]           op_a, op_b;
    logic [WORD_BITS-1:0]           mag_a, mag_b;
    logic signed [WORD_BITS:0]      alu_wide;
    logic [WORD_BITS:0]             alu_sat;
    logic [WORD_BITS+MUL_CHUNK-1:0] mul_pp;
    logic signed [PW-1:0]           mul_s;
    logic [WORD_BITS:0]             mul_sat;
    logic                           alu_wr;
    logic                           wr_en;
    t_dst                           wr_dst;
    logic [WORD_BITS-1:0]           wr_val;
    logic                           wr_flag;

    function automatic logic [WORD_BITS-1:0] pick(input t_src s);
        logic [WORD_BITS-1:0] v;
        unique case (s)
            SRC_X:   v = r_x;
            SRC_Y:   v = r_y;
            SRC_Z:   v = r_z;
            SRC_ONE: v = ONE;
            SRC_A:   v = r_gain_a;
            SRC_B:   v = r_gain_b;
            SRC_C:   v = r_gain_c;
            SRC_D:   v = r_slope_d;
            SRC_E:   v = r_slope_e;
            SRC_H:   v = r_time_step;
            SRC_T1:  v = r_t1;
            SRC_T2:  v = r_t2;
            default: v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        op_a  = pick(i_cmd.uop.src_a);
        op_b  = pick(i_cmd.uop.src_b);
        mag_a = op_a[WORD_BITS-1] ? (WORD_BITS)'(-op_a) : op_a;
        mag_b = op_b[WORD_BITS-1] ? (WORD_BITS)'(-op_b) : op_b;
        unique case (i_cmd.uop.op)
            OP_ADD:  alu_wide = $signed({op_a[WORD_BITS-1], op_a})
                              + $signed({op_b[WORD_BITS-1], op_b});
            OP_SUB:  alu_wide = $signed({op_a[WORD_BITS-1], op_a})
                              - $signed({op_b[WORD_BITS-1], op_b});
            OP_ABS:  alu_wide = op_a[WORD_BITS-1] ? -$signed({op_a[WORD_BITS-1], op_a})
                                                  : $signed({1'b0, op_a});
            default: alu_wide = '0;
        endcase
        alu_sat = sat_w(PW'(alu_wide));
        alu_wr  = i_cmd.issue && (i_cmd.uop.op != OP_MUL);
    end

    // radix-2^16 multiply, multiplier digits taken MSB first
    always_comb begin
        mul_pp = r_mul_a * r_mul_b[BP-1 -: MUL_CHUNK];
        mul_s  = $signed({1'b0, r_mul_acc});
        if (r_mul_neg) begin
            mul_s = -mul_s;
        end
        mul_sat = sat_w(mul_s >>> FRAC_BITS);
    end

    always_comb begin
        wr_en   = alu_wr || r_mul_fin;
        wr_dst  = r_mul_fin ? r_mul_dst : i_cmd.uop.dst;
        wr_val  = r_mul_fin ? mul_sat[WORD_BITS-1:0] : alu_sat[WORD_BITS-1:0];
        wr_flag = r_mul_fin ? mul_sat[WORD_BITS] : alu_sat[WORD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
            r_mul_fin  <= 1'b0;
            r_mul_cnt  <= '0;
        end else if (i_cmd.issue && (i_cmd.uop.op == OP_MUL)) begin
            r_mul_busy <= 1'b1;
            r_mul_fin  <= 1'b0;
            r_mul_cnt  <= CNT_BITS'(NCH);
        end else if (r_mul_busy) begin
            r_mul_cnt <= r_mul_cnt - CNT_BITS'(1);
            if (r_mul_cnt == CNT_BITS'(1)) begin
                r_mul_busy <= 1'b0;
                r_mul_fin  <= 1'b1;
            end
        end else begin
            r_mul_fin <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue && (i_cmd.uop.op == OP_MUL)) begin
            r_mul_a   <= mag_a;
            r_mul_b   <= BP'(mag_b);
            r_mul_neg <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
            r_mul_acc <= '0;
            r_mul_dst <= i_cmd.uop.dst;
        end else if (r_mul_busy) begin
            r_mul_acc <= (r_mul_acc << MUL_CHUNK) + AW'(mul_pp);
            r_mul_b   <= r_mul_b << MUL_CHUNK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            unique case (wr_dst)
                DST_T1:  r_t1 <= wr_val;
                DST_T2:  r_t2 <= wr_val;
                DST_NX:  r_nx <= wr_val;
                DST_NY:  r_ny <= wr_val;
                DST_NZ:  r_nz <= wr_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_hit <= 1'b0;
        end else if (i_cmd.start) begin
            r_sat_hit <= ONE_SAT;
        end else if (wr_en) begin
            r_sat_hit <= r_sat_hit | wr_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= ONE;
            r_y <= ONE;
            r_z <= ONE;
        end else if (i_cmd.commit) begin
            r_x <= r_nx;
            r_y <= r_ny;
            r_z <= r_nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_next_x   <= r_nx;
            o_next_y   <= r_ny;
            o_next_z   <= r_nz;
            o_overflow <= r_sat_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_a    <= RST_A_Q[WORD_BITS-1:0];
            r_gain_b    <= RST_B_Q[WORD_BITS-1:0];
            r_gain_c    <= RST_C_Q[WORD_BITS-1:0];
            r_slope_d   <= RST_D_Q[WORD_BITS-1:0];
            r_slope_e   <= RST_E_Q[WORD_BITS-1:0];
            r_time_step <= RST_H_Q[WORD_BITS-1:0];
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_A:    r_gain_a    <= i_cfg_data;
                CFG_GAIN_B:    r_gain_b    <= i_cfg_data;
                CFG_GAIN_C:    r_gain_c    <= i_cfg_data;
                CFG_SLOPE_D:   r_slope_d   <= i_cfg_data;
                CFG_SLOPE_E:   r_slope_e   <= i_cfg_data;
                CFG_TIME_STEP: r_time_step <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign o_sts.mul_done = r_mul_fin;

endmodule

@@ sv/ceu_ctrl.sv @@
`timescale 1ns / 1ps

module ceu_ctrl import ceu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_tick,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [PC_BITS-1:0] LAST_PC = PC_BITS'(NUM_UOPS - 1);

    t_state               r_state, n_state;
    logic [PC_BITS-1:0]   r_pc, n_pc;
    logic                 r_out_valid, n_out_valid;
    t_uop                 cur_uop;

    assign cur_uop = PROGRAM[r_pc];

    // next state
    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_tick) begin
                    n_state = ST_ISSUE;
                    n_pc    = '0;
                end
            end
            ST_ISSUE: begin
                if (cur_uop.op == OP_MUL) begin
                    n_state = ST_MUL_WAIT;
                end else if (r_pc == LAST_PC) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_pc = r_pc + PC_BITS'(1);
                end
            end
            ST_MUL_WAIT: begin
                if (i_sts.mul_done) begin
                    if (r_pc == LAST_PC) begin
                        n_state = ST_COMMIT;
                    end else begin
                        n_state = ST_ISSUE;
                        n_pc    = r_pc + PC_BITS'(1);
                    end
                end
            end
            ST_COMMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready   = (r_state == ST_IDLE);
        o_out_valid  = r_out_valid;
        o_cmd.start  = (r_state == ST_IDLE) && i_in_valid && i_tick;
        o_cmd.issue  = (r_state == ST_ISSUE);
        o_cmd.uop    = cur_uop;
        o_cmd.commit = (r_state == ST_COMMIT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit while output register still full");

    a_wait_on_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_WAIT) |-> (cur_uop.op == OP_MUL))
        else $error("multiply wait on a non-multiply uop");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= LAST_PC)
        else $error("uop pointer past end of program");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> !o_in_ready)
        else $error("new request taken while a step is running");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid)
        else $error("result not presented after commit");
`endif

endmodule

@@ dv/chua_attractor_euler_step_unit_tb.sv @@
`timescale 1ns / 1ps

module chua_attractor_euler_step_unit_tb;
    import ceu_pkg::*;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 24;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int NUM_CFG_REGS = 6;
    // settle margin after the last point, longer than one step at 32-bit words
    localparam int SETTLE_CYCLES = 64;
    // worst quiet stretch: one step + longest tick gap + longest stall
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 100;

    typedef logic signed [WORD_BITS-1:0]   t_word;
    typedef logic signed [2*WORD_BITS-1:0] t_wide;

    typedef struct {
        t_word x;
        t_word y;
        t_word z;
        logic  ovf;
    } t_point;

    // how a phase picks its coefficients
    typedef enum {
        MIX_DEFAULT,
        MIX_GENTLE,
        MIX_WILD,
        MIX_EDGES
    } t_cfg_mix;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word ONE_Q    = t_word'(1) <<< FRAC_BITS;

    // power-on coefficients, in register index order
    localparam t_word CFG_RESET [NUM_CFG_REGS] = '{
        243269632,   // a = 14.5
        16777216,    // b = 1.0
        429161185,   // c = 25.58
        -16777216,   // d = -1.0
        0,           // e = 0.0
        167772       // h = 0.01
    };

    // indexes past the register file; writes there must be dropped
    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ceu_tick_if                               tick_ch ();
    ceu_cfg_if    #(.WORD_BITS(WORD_BITS))    cfg_ch ();
    ceu_result_if #(.WORD_BITS(WORD_BITS))    result_ch ();

    chua_attractor_euler_step_unit #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick_ch),
        .i_cfg   (cfg_ch),
        .o_result(result_ch)
    );

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Step model state: coefficients and the current point.
    // ------------------------------------------------------------------
    t_word  coef [NUM_CFG_REGS];
    t_word  pt_x, pt_y, pt_z;
    logic   step_clamped;        // any saturation in the step being modeled
    t_point point_expect_q [$];  // predicted points, oldest first
    bit     tick_backlog [$];    // tick requests waiting for the driver

    bit  calm;                   // phase with no idling on either side
    int  err_count;
    int  results_seen;
    int  gap_left;
    int  stall_left;
    int  quiet_cycles;
    t_point want;

    function automatic t_wide widen(input t_word a);
        return $signed({{WORD_BITS{a[WORD_BITS-1]}}, a});
    endfunction

    // clamp to word range, noting any saturation for the overflow bit
    function automatic t_word clamp_word(input t_wide v);
        t_wide top;
        top = v >>> (WORD_BITS - 1);
        if (top == '0 || top == '1)
            return v[WORD_BITS-1:0];
        step_clamped = 1'b1;
        return v[2*WORD_BITS-1] ? WORD_MIN : WORD_MAX;
    endfunction

    function automatic t_word q_add(input t_word a, input t_word b);
        return clamp_word(widen(a) + widen(b));
    endfunction

    function automatic t_word q_sub(input t_word a, input t_word b);
        return clamp_word(widen(a) - widen(b));
    endfunction

    // full product, floor shift by the fraction width
    function automatic t_word q_mul(input t_word a, input t_word b);
        t_wide prod;
        prod = widen(a) * widen(b);
        return clamp_word(prod >>> FRAC_BITS);
    endfunction

    // |min code| saturates to max code
    function automatic t_word q_abs(input t_word a);
        return (a < 0) ? clamp_word(-widen(a)) : a;
    endfunction

    // One Euler step from the stored point; every term uses the old point.
    function automatic void euler_step_predict();
        t_word  x, y, z, unit, spread, pull;
        t_point nxt;
        x = pt_x;
        y = pt_y;
        z = pt_z;
        step_clamped = 1'b0;
        unit = clamp_word(t_wide'(1) <<< FRAC_BITS);

        nxt.z = q_sub(z, q_mul(q_mul(coef[CFG_TIME_STEP], coef[CFG_GAIN_C]), y));
        nxt.y = q_add(y, q_mul(q_mul(coef[CFG_TIME_STEP], coef[CFG_GAIN_B]),
                               q_add(q_sub(x, y), z)));
        // piecewise-linear diode term; (d+e) factor on purpose
        spread = q_sub(q_abs(q_add(x, unit)), q_abs(q_sub(x, unit)));
        pull   = q_add(q_mul(coef[CFG_SLOPE_E], x),
                       q_mul(q_add(coef[CFG_SLOPE_D], coef[CFG_SLOPE_E]), spread));
        nxt.x = q_add(x, q_mul(q_mul(coef[CFG_TIME_STEP], coef[CFG_GAIN_A]),
                               q_sub(q_sub(y, x), pull)));
        nxt.ovf = step_clamped;

        pt_x = nxt.x;
        pt_y = nxt.y;
        pt_z = nxt.z;
        point_expect_q.push_back(nxt);
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        $display("[%0t] mismatch #%0d: %s", $time, err_count, msg);
    endtask

    // mostly back-to-back or short, now and then a long pause
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic t_word signed_span(input int unsigned r);
        return t_word'($urandom_range(0, 2*r)) - t_word'(r);
    endfunction

    function automatic t_word pick_coef(input t_cfg_mix mix, input int idx);
        case (mix)
            MIX_DEFAULT: return CFG_RESET[idx];
            // |h| <= 0.25, |gain|, |slope| <= 16: trajectories that wander for a while
            MIX_GENTLE:  return (idx == CFG_TIME_STEP) ? signed_span(1 << 22)
                                                       : signed_span(1 << 28);
            MIX_WILD:    return t_word'($urandom);
            default: begin
                case ($urandom_range(0, 5))
                    0: return WORD_MAX;
                    1: return WORD_MIN;
                    2: return '0;
                    3: return '1;
                    4: return ONE_Q;
                    default: return t_word'($urandom);
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tick driver: one request per backlog entry, random gaps between.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_ch.valid <= 1'b0;
            tick_ch.tick  <= 1'b0;
            gap_left = 0;
        end else begin
            if (tick_ch.valid && tick_ch.ready && tick_ch.tick)
                euler_step_predict();
            if (!tick_ch.valid || tick_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    tick_ch.valid <= 1'b0;
                end else if (tick_backlog.size() > 0) begin
                    tick_ch.valid <= 1'b1;
                    tick_ch.tick  <= tick_backlog.pop_front();
                    gap_left = pick_gap();
                end else begin
                    tick_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, field-by-field compare.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (point_expect_q.size() == 0) begin
                    flag_error($sformatf("unrequested point x=%0d y=%0d z=%0d ovf=%0b",
                                         result_ch.next_x, result_ch.next_y,
                                         result_ch.next_z, result_ch.overflow));
                end else begin
                    want = point_expect_q.pop_front();
                    if (result_ch.next_x !== want.x)
                        flag_error($sformatf("point %0d next_x got %0d want %0d",
                                             results_seen, result_ch.next_x, want.x));
                    if (result_ch.next_y !== want.y)
                        flag_error($sformatf("point %0d next_y got %0d want %0d",
                                             results_seen, result_ch.next_y, want.y));
                    if (result_ch.next_z !== want.z)
                        flag_error($sformatf("point %0d next_z got %0d want %0d",
                                             results_seen, result_ch.next_z, want.z));
                    if (result_ch.overflow !== want.ovf)
                        flag_error($sformatf("point %0d overflow got %0b want %0b",
                                             results_seen, result_ch.overflow, want.ovf));
                end
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any handshake means the unit hung.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((tick_ch.valid && tick_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
                (result_ch.valid && result_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Register write; the model picks it up at the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input t_word data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx < NUM_CFG_REGS)
            coef[idx] = data;
    endtask

    task automatic load_coefs(input t_cfg_mix mix);
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_reg(CFG_IDX_BITS'(i), pick_coef(mix, i));
    endtask

    // Queue n real ticks with some tick-low noise mixed in.
    task automatic queue_ticks(input int n);
        int  real_ticks;
        bit  t;
        real_ticks = 0;
        while (real_ticks < n) begin
            t = ($urandom_range(0, 9) != 0);
            tick_backlog.push_back(t);
            if (t)
                real_ticks++;
        end
    endtask

    // Quiet point: backlog sent, all points back, then let the datapath settle.
    // Checked mid-cycle so the driver's edge updates have all landed.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (tick_backlog.size() > 0 || tick_ch.valid || point_expect_q.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        tick_ch.valid   = 1'b0;
        tick_ch.tick    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b0;
        calm            = 1'b0;
        err_count       = 0;
        results_seen    = 0;
        for (int i = 0; i < NUM_CFG_REGS; i++)
            coef[i] = CFG_RESET[i];
        pt_x = ONE_Q;
        pt_y = ONE_Q;
        pt_z = ONE_Q;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // power-on coefficients from (1,1,1); tick-low in the middle
        tick_backlog = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
        wait_idle();

        // writes past the register file must not land anywhere
        write_reg(IDX_SPARE_LO, WORD_MAX);
        write_reg(IDX_SPARE_HI, WORD_MIN);
        tick_backlog.push_back(1'b1);
        wait_idle();

        // zero step: point must hold
        write_reg(CFG_TIME_STEP, '0);
        tick_backlog = '{1'b1, 1'b1};
        wait_idle();

        // everything at max: products saturate
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_reg(CFG_IDX_BITS'(i), WORD_MAX);
        tick_backlog = '{1'b1, 1'b1, 1'b1};
        wait_idle();

        // everything at min, incl. |min| and min*min
        for (int i = 0; i < NUM_CFG_REGS; i++)
            write_reg(CFG_IDX_BITS'(i), WORD_MIN);
        tick_backlog = '{1'b1, 1'b1, 1'b1};
        wait_idle();

        // unit step, opposing slopes
        write_reg(CFG_TIME_STEP, ONE_Q);
        write_reg(CFG_GAIN_A, WORD_MAX);
        write_reg(CFG_GAIN_B, '1);
        write_reg(CFG_GAIN_C, '0);
        write_reg(CFG_SLOPE_D, WORD_MIN);
        write_reg(CFG_SLOPE_E, WORD_MAX);
        tick_backlog = '{1'b1, 1'b0, 1'b1, 1'b1};
        wait_idle();

        // random phases; each starts from a quiet unit with fresh coefficients
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0: load_coefs(MIX_DEFAULT);
                1: load_coefs(MIX_GENTLE);
                2: load_coefs(MIX_WILD);
                default: load_coefs(MIX_EDGES);
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_BITS'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)),
                          t_word'($urandom));
            calm = ($urandom_range(0, 3) == 0);
            queue_ticks(PHASE_TICKS);
            wait_idle();
        end
        calm = 1'b0;

        wait_idle();
        while (point_expect_q.size() > 0) begin
            want = point_expect_q.pop_front();
            flag_error($sformatf("point never arrived x=%0d y=%0d z=%0d",
                                 want.x, want.y, want.z));
        end
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
